### hdl/pge_pkg.sv
// ----------------------------------------------------------------------------
// pge_pkg
// Shared types and constants for the previous greater element unit: payload
// structs, stack entry layout and controller/datapath command and status.
// ----------------------------------------------------------------------------
package pge_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic [31:0] item_tag;
    logic [31:0] item_value;
    logic        last_in_case;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] previous_tag;
    logic        case_end;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] value;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic pop;
    logic load_top;
    logic finish;
  } pge_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_needed;
  } pge_sts_t;

endpackage

### hdl/pge_datapath.sv
// ----------------------------------------------------------------------------
// pge_datapath
// Stack memory, stack count, cached top entry, sticky overflow flag and the
// result register. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module pge_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  pge_pkg::in_item_t  in_item,
  input  pge_pkg::pge_cmd_t  cmd,
  output pge_pkg::pge_sts_t  sts,
  output pge_pkg::out_item_t out_item
);
  import pge_pkg::*;

  entry_t               mem [STACK_DEPTH];
  entry_t               rd_data_r;
  entry_t               top_r;
  entry_t               top_nxt;
  in_item_t             item_r;
  out_item_t            out_r;
  out_item_t            out_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 overflow_r;
  logic                 overflow_nxt;
  logic                 not_empty;
  logic                 has_room;
  logic                 push_we;
  logic [CNT_W-1:0]     rd_cnt;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;

  // stack status
  assign not_empty      = (count_r != '0);
  assign has_room       = (count_r < CNT_W'(STACK_DEPTH));
  assign sts.pop_needed = not_empty && (top_r.value <= item_r.item_value);
  assign push_we        = cmd.finish && has_room;

  // entry below the top becomes the new top after a pop
  assign rd_cnt  = count_r - CNT_W'(2);
  assign rd_addr = rd_cnt[ADDR_W-1:0];
  assign wr_addr = count_r[ADDR_W-1:0];

  // next state of count, top, flag and result
  always_comb begin
    count_nxt    = count_r;
    top_nxt      = top_r;
    overflow_nxt = overflow_r;
    out_nxt      = out_r;
    if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.load_top) begin
      top_nxt = rd_data_r;
    end
    if (cmd.finish) begin
      if (has_room) begin
        count_nxt     = count_r + CNT_W'(1);
        top_nxt.tag   = item_r.item_tag;
        top_nxt.value = item_r.item_value;
      end else begin
        overflow_nxt = 1'b1;
      end
      if (item_r.last_in_case) begin
        count_nxt = '0;
      end
      out_nxt.found        = not_empty;
      out_nxt.previous_tag = not_empty ? top_r.tag : 32'd0;
      out_nxt.case_end     = item_r.last_in_case;
      out_nxt.overflow     = overflow_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    top_r <= top_nxt;
    out_r <= out_nxt;
  end

  // stack memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (push_we) begin
      mem[wr_addr] <= '{tag: item_r.item_tag, value: item_r.item_value};
    end
    if (cmd.pop) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_item = out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |=> overflow_r)
    else $error("overflow flag cleared");

  a_case_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && item_r.last_in_case |=> count_r == '0)
    else $error("stack not cleared at end of case");

  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> not_empty ##1 count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not drop count by one");
`endif

endmodule

### hdl/pge_ctrl.sv
// ----------------------------------------------------------------------------
// pge_ctrl
// Sequencer for one item: accept, pop entries while the top is not greater,
// then push and post the result. Owns the handshake valid/ready flags.
// ----------------------------------------------------------------------------
module pge_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pge_pkg::pge_sts_t sts,
  output pge_pkg::pge_cmd_t cmd
);
  import pge_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_LOAD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  // result slot frees up when empty or taken this cycle
  assign out_free = !out_valid_r || out_ready;

  assign in_ready      = (state_r == ST_IDLE);
  assign cmd.load_item = in_ready && in_valid;
  assign cmd.pop       = (state_r == ST_CMP) && sts.pop_needed;
  assign cmd.load_top  = (state_r == ST_LOAD);
  assign cmd.finish    = (state_r == ST_CMP) && !sts.pop_needed && out_free;

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (sts.pop_needed) begin
            state_r <= ST_LOAD;
          end else if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          state_r <= ST_CMP;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r || out_ready)
    else $error("result written over a pending transfer");

  a_load_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> cmd.load_top)
    else $error("pop not followed by top reload");

  a_finish_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready && out_valid_r)
    else $error("no result or not idle after finish");
`endif

endmodule

### hdl/previous_greater_element_unit.sv
// ----------------------------------------------------------------------------
// previous_greater_element_unit
// Streaming previous greater element search over a monotonic stack.
// ----------------------------------------------------------------------------
// For each (tag, value) item the unit returns the tag of the most recent
// earlier item in the same case with a strictly greater value, or found = 0
// and tag 0. An item is accepted, then pops every stack entry that is not
// greater, each pop reading the next top from the single-port stack memory
// with a registered read, then is pushed and its result posted; as every
// item is pushed at most once, it is popped at most once. A new item is
// taken while the previous result still waits on the output. The stack
// holds STACK_DEPTH entries; a push onto a full stack is dropped and sets a
// sticky overflow flag that only reset clears. No clearing pass is needed
// after reset.
module previous_greater_element_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pge_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output pge_pkg::out_item_t out_item
);
  import pge_pkg::*;

  pge_cmd_t cmd;
  pge_sts_t sts;

  // sequencer
  pge_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stack and result datapath
  pge_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

### test/previous_greater_element_checker.sv
// ----------------------------------------------------------------------------
// previous_greater_element_checker
// Watches both channels of the previous greater element unit, predicts the
// answer for every input transfer on its own monotonic stack and compares
// each result transfer, field by field, with the oldest predicted answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module previous_greater_element_checker
  import pge_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        error_count,
  output int        answers_owed,
  output int        answers_checked,
  output int        answers_found,
  output int        deepest_stack,
  output logic      overflow_reached
);

  // private copy of the stack, values strictly decreasing toward the top
  entry_t    mono_stack [STACK_DEPTH];
  int        stack_len;
  out_item_t owed_answers [$];

  // pop smaller or equal entries, read the top, push, then clear on case end
  function automatic out_item_t resolve_previous_greater(in_item_t item);
    out_item_t answer;
    answer = '0;
    while (stack_len > 0 && mono_stack[stack_len - 1].value <= item.item_value) begin
      stack_len--;
    end
    if (stack_len > 0) begin
      answer.found        = 1'b1;
      answer.previous_tag = mono_stack[stack_len - 1].tag;
    end
    if (stack_len < STACK_DEPTH) begin
      mono_stack[stack_len] = '{tag: item.item_tag, value: item.item_value};
      stack_len++;
    end else begin
      // full stack: push refused, flag stays set until reset
      overflow_reached = 1'b1;
    end
    if (stack_len > deepest_stack) begin
      deepest_stack = stack_len;
    end
    if (item.last_in_case) begin
      stack_len = 0;
    end
    answer.case_end = item.last_in_case;
    answer.overflow = overflow_reached;
    return answer;
  endfunction

  // compare result transfers first, then record the new input transfer
  always @(posedge clk) begin : watch
    out_item_t wanted;
    logic      bad;
    if (!rst_n) begin
      stack_len        = 0;
      overflow_reached = 1'b0;
      owed_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_answers.size() == 0) begin
          $display("%0t: result with no answer owed, actual %p", $time, out_item);
          error_count++;
        end else begin
          wanted = owed_answers[0];
          owed_answers.delete(0);
          bad    = 1'b0;
          if (out_item.found !== wanted.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, wanted.found, out_item.found);
            bad = 1'b1;
          end
          if (out_item.previous_tag !== wanted.previous_tag) begin
            $display("%0t: previous_tag mismatch, expected %h, actual %h",
                     $time, wanted.previous_tag, out_item.previous_tag);
            bad = 1'b1;
          end
          if (out_item.case_end !== wanted.case_end) begin
            $display("%0t: case_end mismatch, expected %0b, actual %0b",
                     $time, wanted.case_end, out_item.case_end);
            bad = 1'b1;
          end
          if (out_item.overflow !== wanted.overflow) begin
            $display("%0t: overflow mismatch, expected %0b, actual %0b",
                     $time, wanted.overflow, out_item.overflow);
            bad = 1'b1;
          end
          if (bad) begin
            error_count++;
          end
          answers_checked++;
          if (wanted.found) begin
            answers_found++;
          end
        end
      end
      if (in_valid && in_ready) begin
        owed_answers = {owed_answers, resolve_previous_greater(in_item)};
      end
    end
    answers_owed = owed_answers.size();
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for previous_greater_element_unit: directed corner items, then
// random cases of mixed shape with idle gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pge_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 680;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int   error_count;
  int   answers_owed;
  int   answers_checked;
  int   answers_found;
  int   deepest_stack;
  logic overflow_reached;

  int items_sent  = 0;
  int cases_sent  = 0;
  int idle_cycles = 0;
  int ready_left  = 0;
  bit gaps_off    = 1'b0;
  bit stalls_off  = 1'b0;

  previous_greater_element_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  previous_greater_element_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .error_count     (error_count),
    .answers_owed    (answers_owed),
    .answers_checked (answers_checked),
    .answers_found   (answers_found),
    .deepest_stack   (deepest_stack),
    .overflow_reached(overflow_reached)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: alternating ready and stall stretches
  always @(negedge clk) begin
    if (stalls_off) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left = ready_left - 1;
    end else begin
      out_ready  <= !out_ready;
      ready_left = out_ready ? pick_gap() : $urandom_range(0, 15);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: %0d cycles without a transfer", IDLE_LIMIT);
    $display("previous_greater_element_unit regression: fail");
    $finish;
  end

  // one input transfer; called and returns at a falling edge with valid high
  task automatic send_item(logic [31:0] tag, logic [31:0] value, logic last);
    int gap;
    gap = gaps_off ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= '{item_tag: tag, item_value: value, last_in_case: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    if (last) cases_sent++;
  endtask

  // hold the sender until every owed answer has come back
  task automatic drain_answers();
    in_valid <= 1'b0;
    do @(negedge clk); while (answers_owed != 0);
  endtask

  // one case of random shape and length
  task automatic random_case();
    int          len;
    int          shape;
    logic [31:0] v;
    logic [31:0] t;
    shape = $urandom_range(0, 99);
    len   = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 16);
    v     = $urandom;
    for (int i = 0; i < len; i++) begin
      if (shape < 35) begin
        // narrow range, many equal values
        v = $urandom_range(0, 7);
      end else if (shape < 60) begin
        v = $urandom;
      end else if (shape < 80) begin
        // mostly falling, builds a deep stack
        if (v > 32'h0010_0000 && $urandom_range(0, 9) != 0) begin
          v = v - $urandom_range(1, 32'h0010_0000);
        end else begin
          v = $urandom;
        end
      end else if (shape < 90) begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'hAAAA_AAAA;
          3: v = 32'h5555_5555;
          default: v = 32'h1 << $urandom_range(0, 31);
        endcase
      end else begin
        // rising, pops on nearly every item
        v = (v < 32'hFFFF_0000) ? v + $urandom_range(0, 32'hFFFF) : $urandom_range(0, 255);
      end
      t = ($urandom_range(0, 3) == 0) ? items_sent : $urandom;
      send_item(t, v, i == len - 1);
    end
  endtask

  // stimulus
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, tag zero as answer, equal values, lone item
    send_item(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_item(32'h1234_5678, 32'h0000_0000, 1'b0);
    send_item(32'hAAAA_AAAA, 32'h0000_0005, 1'b0);
    send_item(32'h5555_5555, 32'h0000_0005, 1'b0);
    send_item(32'h0000_0001, 32'h0000_0004, 1'b0);
    send_item(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    send_item(32'h0000_0007, 32'h0000_0000, 1'b1);
    for (int i = 0; i < 5; i++) begin
      send_item(32'h100 + i, 32'h1000 - i * 16, 1'b0);
    end
    send_item(32'h0000_0200, 32'h0000_0FE8, 1'b0);
    send_item(32'h0000_0201, 32'h8000_0000, 1'b1);
    send_item(32'hDEAD_BEEF, 32'h7FFF_FFFF, 1'b0);
    send_item(32'h2152_4110, 32'h8000_0000, 1'b1);
    drain_answers();

    // random cases, idling switched off now and then
    while (items_sent < RANDOM_ITEMS) begin
      gaps_off   = ($urandom_range(0, 5) == 0);
      stalls_off = ($urandom_range(0, 5) == 0);
      random_case();
      if ($urandom_range(0, 7) == 0) drain_answers();
    end
    gaps_off   = 1'b0;
    stalls_off = 1'b0;

    // wait for the last answers, then a short tail
    in_valid <= 1'b0;
    while (answers_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("run covered %0d items in %0d cases, %0d answers checked, %0d found",
             items_sent, cases_sent, answers_checked, answers_found);
    $display("deepest stack %0d of %0d entries, refused push %s",
             deepest_stack, STACK_DEPTH, overflow_reached ? "seen" : "not seen");
    if (error_count == 0 && answers_owed == 0) begin
      $display("previous_greater_element_unit regression: pass");
    end else begin
      $display("previous_greater_element_unit regression: fail");
    end
    $finish;
  end

endmodule

### files.f
hdl/pge_pkg.sv
hdl/pge_datapath.sv
hdl/pge_ctrl.sv
hdl/previous_greater_element_unit.sv
test/previous_greater_element_checker.sv
test/tb.sv
